// ----- src/okr_pkg.sv -----
`timescale 1ns / 1ps

package okr_pkg;

	localparam int TICK_W = 16;
	localparam int THR_W = 12;
	localparam int ERR_W = 14;
	localparam int REPEAT_W = 8;
	localparam int GAP_SHIFT = 4;

	localparam logic [TICK_W-1:0] SYNC_RESET = 16'd9000;
	localparam logic [REPEAT_W-1:0] REPEAT_MAX = 8'hFF;

	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_POP = 1'b1;

	typedef struct packed {
		logic pop;
		logic sync;
		logic [TICK_W-1:0] ticks;
		logic pin;
	} okr_cmd_t;

endpackage

// ----- src/okr_fifo.sv -----
`timescale 1ns / 1ps

module okr_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  okr_pkg::okr_cmd_t din,
	output logic             full,
	input  logic             pop,
	output okr_pkg::okr_cmd_t dout,
	output logic             not_empty
);
	import okr_pkg::*;

	okr_cmd_t entry_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign do_push = push && !full;
	assign do_pop = pop && not_empty;
	assign dout = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10: begin
					count_q <= count_q + 2'd1;
				end
				2'b01: begin
					count_q <= count_q - 2'd1;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

endmodule

// ----- src/okr_front.sv -----
`timescale 1ns / 1ps

module okr_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [okr_pkg::TICK_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        opcode,
	input  logic [okr_pkg::TICK_W-1:0]  interval_ticks,
	input  logic                        pin_level,
	input  logic                        fifo_full,
	output logic                        push,
	output okr_pkg::okr_cmd_t           cmd
);
	import okr_pkg::*;

	logic [TICK_W-1:0] sync_min_q;

	assign cfg_ready = 1'b1;
	assign in_stall = fifo_full;
	assign push = in_valid && !fifo_full;

	always_comb begin
		cmd.pop = (opcode == OP_POP);
		cmd.sync = (opcode == OP_EDGE) && (interval_ticks > sync_min_q);
		cmd.ticks = interval_ticks;
		cmd.pin = pin_level;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_min_q <= SYNC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			sync_min_q <= cfg_data;
		end
	end

endmodule

// ----- src/okr_back.sv -----
`timescale 1ns / 1ps

module okr_back #(
	parameter int CODE_BITS = 24,
	parameter int QUEUE_DEPTH = 5
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  okr_pkg::okr_cmd_t                     cmd,
	input  logic                                  cmd_valid,
	output logic                                  cmd_take,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  frame_done,
	output logic [CODE_BITS-1:0]                  frame_code,
	output logic [okr_pkg::REPEAT_W-1:0]          repeat_count,
	output logic                                  code_queued,
	output logic                                  pop_valid,
	output logic [CODE_BITS-1:0]                  pop_code,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]      queue_count
);
	import okr_pkg::*;

	localparam int BC_W = $clog2(CODE_BITS + 2);
	localparam int QC_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [BC_W-1:0] BC_FULL = BC_W'(CODE_BITS);
	localparam logic [QC_W-1:0] QC_FULL = QC_W'(QUEUE_DEPTH);

	logic synced_q, synced_nx;
	logic [THR_W-1:0] thr_q, thr_nx;
	logic [ERR_W-1:0] err_q, err_nx;
	logic [CODE_BITS-1:0] shift_q, shift_nx;
	logic [BC_W-1:0] bc_q, bc_nx;
	logic [CODE_BITS-1:0] prev_q, prev_nx;
	logic [CODE_BITS-1:0] acc_q, acc_nx;
	logic [REPEAT_W-1:0] rep_q, rep_nx;
	logic [CODE_BITS-1:0] queue_q [QUEUE_DEPTH];
	logic [CODE_BITS-1:0] queue_nx [QUEUE_DEPTH];
	logic [QC_W-1:0] fill_q, fill_nx;

	logic hit;
	logic done_nx, queued_nx, pvalid_nx;
	logic [CODE_BITS-1:0] fcode_nx, pcode_nx;

	logic out_valid_q;
	logic done_q, queued_q, pvalid_q;
	logic [CODE_BITS-1:0] fcode_q, pcode_q;
	logic [REPEAT_W-1:0] rcount_q;
	logic [QC_W-1:0] qcount_q;

	assign cmd_take = cmd_valid && (!out_valid_q || !out_stall);

	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if ((QC_W'(i) < fill_q) && (queue_q[i] == shift_q)) begin
				hit = 1'b1;
			end
		end

		synced_nx = synced_q;
		thr_nx = thr_q;
		err_nx = err_q;
		shift_nx = shift_q;
		bc_nx = bc_q;
		prev_nx = prev_q;
		acc_nx = acc_q;
		rep_nx = rep_q;
		fill_nx = fill_q;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			queue_nx[i] = queue_q[i];
		end
		done_nx = 1'b0;
		fcode_nx = '0;
		queued_nx = 1'b0;
		pvalid_nx = 1'b0;
		pcode_nx = '0;

		if (cmd.pop) begin
			if (fill_q != '0) begin
				pvalid_nx = 1'b1;
				pcode_nx = queue_q[0];
				for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
					queue_nx[i] = queue_q[i+1];
				end
				queue_nx[QUEUE_DEPTH-1] = '0;
				fill_nx = fill_q - QC_W'(1);
			end
		end else if (cmd.sync) begin
			thr_nx = cmd.ticks[TICK_W-1:GAP_SHIFT];
			err_nx = {1'b0, thr_nx, 1'b0} + {2'b00, thr_nx};
			if (bc_q == BC_FULL) begin
				done_nx = 1'b1;
				fcode_nx = shift_q;
				if (shift_q != prev_q) begin
					rep_nx = '0;
					prev_nx = shift_q;
				end else begin
					if (rep_q != REPEAT_MAX) begin
						rep_nx = rep_q + REPEAT_W'(1);
					end
					if (shift_q != acc_q) begin
						acc_nx = shift_q;
						if (!hit) begin
							queued_nx = 1'b1;
							if (fill_q != QC_FULL) begin
								for (int i = 0; i < QUEUE_DEPTH; i++) begin
									if (QC_W'(i) == fill_q) begin
										queue_nx[i] = shift_q;
									end
								end
								fill_nx = fill_q + QC_W'(1);
							end else begin
								for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
									queue_nx[i] = queue_q[i+1];
								end
								queue_nx[QUEUE_DEPTH-1] = shift_q;
							end
						end
					end
				end
			end
			synced_nx = 1'b1;
			shift_nx = '0;
			bc_nx = '0;
		end else if (cmd.ticks > {2'b00, err_q}) begin
			synced_nx = 1'b0;
			shift_nx = '0;
			bc_nx = '0;
		end else if (cmd.pin) begin
			if (!synced_q) begin
				shift_nx = '0;
				bc_nx = '0;
			end else begin
				if (bc_q < BC_FULL) begin
					shift_nx = {shift_q[CODE_BITS-2:0], (cmd.ticks <= {4'b0000, thr_q})};
				end
				if (bc_q <= BC_FULL) begin
					bc_nx = bc_q + BC_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			synced_q <= 1'b0;
			thr_q <= '0;
			err_q <= '0;
			shift_q <= '0;
			bc_q <= '0;
			prev_q <= '0;
			acc_q <= '0;
			rep_q <= '0;
			fill_q <= '0;
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				queue_q[i] <= '0;
			end
		end else if (cmd_take) begin
			synced_q <= synced_nx;
			thr_q <= thr_nx;
			err_q <= err_nx;
			shift_q <= shift_nx;
			bc_q <= bc_nx;
			prev_q <= prev_nx;
			acc_q <= acc_nx;
			rep_q <= rep_nx;
			fill_q <= fill_nx;
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				queue_q[i] <= queue_nx[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			done_q <= done_nx;
			fcode_q <= fcode_nx;
			rcount_q <= rep_nx;
			queued_q <= queued_nx;
			pvalid_q <= pvalid_nx;
			pcode_q <= pcode_nx;
			qcount_q <= fill_nx;
		end
	end

	assign out_valid = out_valid_q;
	assign frame_done = done_q;
	assign frame_code = fcode_q;
	assign repeat_count = rcount_q;
	assign code_queued = queued_q;
	assign pop_valid = pvalid_q;
	assign pop_code = pcode_q;
	assign queue_count = qcount_q;

endmodule

// ----- src/ook_pulse_width_code_receiver_core.sv -----
`timescale 1ns / 1ps

// Receiver for 24-bit on-off-keyed remote codes sent with pulse-width coding.
// The input channel takes one request per cycle unless in_stall is high: an
// edge event with the timer ticks since the previous edge and the new pin
// level, or a pop of the oldest queued code. Every request yields exactly one
// result on the output channel. The configuration channel writes the sync
// gap threshold; it is always ready and should be written only while no
// request is in flight. An accepted request waits in a buffer until the
// decoder takes it, and its result is registered on the output ports.
// The decoder takes one request per cycle while the output is not stalled,
// with a combinational decode and a parallel compare against every queue entry.
// A two-entry buffer sits between the input stage and the decoder, and the
// result sits in an output register. When the receiver stalls, the result is
// held and up to two more requests are absorbed before in_stall rises.
// Reset clears the decoder, the code queue, the repeat count and the buffer,
// and returns the sync threshold to 9000 ticks.

module ook_pulse_width_code_receiver_core #(
	parameter int CODE_BITS = 24,
	parameter int QUEUE_DEPTH = 5
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [okr_pkg::TICK_W-1:0]            cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  opcode,
	input  logic [okr_pkg::TICK_W-1:0]            interval_ticks,
	input  logic                                  pin_level,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  frame_done,
	output logic [CODE_BITS-1:0]                  frame_code,
	output logic [okr_pkg::REPEAT_W-1:0]          repeat_count,
	output logic                                  code_queued,
	output logic                                  pop_valid,
	output logic [CODE_BITS-1:0]                  pop_code,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]      queue_count
);
	import okr_pkg::*;

	okr_cmd_t front_cmd;
	okr_cmd_t back_cmd;
	logic front_push;
	logic fifo_full;
	logic fifo_not_empty;
	logic back_take;

	okr_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.interval_ticks (interval_ticks),
		.pin_level      (pin_level),
		.fifo_full      (fifo_full),
		.push           (front_push),
		.cmd            (front_cmd)
	);

	okr_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_push),
		.din       (front_cmd),
		.full      (fifo_full),
		.pop       (back_take),
		.dout      (back_cmd),
		.not_empty (fifo_not_empty)
	);

	okr_back #(
		.CODE_BITS   (CODE_BITS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (back_cmd),
		.cmd_valid    (fifo_not_empty),
		.cmd_take     (back_take),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_done   (frame_done),
		.frame_code   (frame_code),
		.repeat_count (repeat_count),
		.code_queued  (code_queued),
		.pop_valid    (pop_valid),
		.pop_code     (pop_code),
		.queue_count  (queue_count)
	);

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (queue_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH)))
		else $error("queue count above queue depth");

	a_pop_or_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(pop_valid && frame_done))
		else $error("pop result and frame result in one request");

	a_queued_needs_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && code_queued) |-> (frame_done && (repeat_count != '0)))
		else $error("code queued without a repeated frame");

	a_stall_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (fifo_not_empty && out_valid))
		else $error("input stalled while decoder could take requests");
`endif

endmodule

// ----- tb/sv/okr_code_tracker.sv -----
`timescale 1ns / 1ps

module okr_code_tracker #(
	parameter int CODE_BITS = 24,
	parameter int QUEUE_DEPTH = 5
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	input  logic                                  cfg_ready,
	input  logic [okr_pkg::TICK_W-1:0]            cfg_data,
	input  logic                                  in_valid,
	input  logic                                  in_stall,
	input  logic                                  opcode,
	input  logic [okr_pkg::TICK_W-1:0]            interval_ticks,
	input  logic                                  pin_level,
	input  logic                                  out_valid,
	input  logic                                  out_stall,
	input  logic                                  frame_done,
	input  logic [CODE_BITS-1:0]                  frame_code,
	input  logic [okr_pkg::REPEAT_W-1:0]          repeat_count,
	input  logic                                  code_queued,
	input  logic                                  pop_valid,
	input  logic [CODE_BITS-1:0]                  pop_code,
	input  logic [$clog2(QUEUE_DEPTH+1)-1:0]      queue_count,
	output int                                    fails,
	output int                                    pending,
	output int                                    results_checked,
	output int                                    frames_seen,
	output int                                    codes_queued_seen,
	output int                                    codes_popped
);

	import okr_pkg::*;

	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam int ERROR_FACTOR = 3;

	typedef struct packed {
		logic frame_done;
		logic [CODE_BITS-1:0] frame_code;
		logic [REPEAT_W-1:0] repeat_count;
		logic code_queued;
		logic pop_valid;
		logic [CODE_BITS-1:0] pop_code;
		logic [FILL_W-1:0] queue_count;
	} decode_result_t;

	logic [TICK_W-1:0] sync_min;
	logic synced;
	logic [THR_W-1:0] bit_thr;
	logic [ERR_W-1:0] err_lim;
	logic [CODE_BITS-1:0] shift_word;
	logic [4:0] bit_cnt;
	logic [CODE_BITS-1:0] prev_frame;
	logic [CODE_BITS-1:0] accepted;
	logic [REPEAT_W-1:0] repeats;
	logic [CODE_BITS-1:0] code_store [0:QUEUE_DEPTH-1];
	logic [FILL_W-1:0] fill;

	decode_result_t decodes_due [$];
	decode_result_t want;

	function automatic void drop_oldest();
		int i;
		for (i = 0; i + 1 < QUEUE_DEPTH; i++)
			code_store[i] = code_store[i + 1];
		code_store[QUEUE_DEPTH - 1] = '0;
	endfunction

	function automatic decode_result_t predict_decode(input logic op,
			input logic [TICK_W-1:0] ticks, input logic pin);
		decode_result_t r;
		logic [CODE_BITS-1:0] code;
		logic held;
		int i;
		r = '0;
		if (op == OP_POP) begin
			if (fill != 0) begin
				r.pop_valid = 1'b1;
				r.pop_code = code_store[0];
				drop_oldest();
				fill = fill - 1'b1;
			end
		end else if (ticks > sync_min) begin
			bit_thr = THR_W'(ticks >> GAP_SHIFT);
			err_lim = ERR_W'(bit_thr) * ERR_W'(ERROR_FACTOR);
			if (bit_cnt == CODE_BITS) begin
				code = shift_word;
				r.frame_done = 1'b1;
				r.frame_code = code;
				if (code != prev_frame) begin
					repeats = '0;
					prev_frame = code;
				end else begin
					if (repeats != REPEAT_MAX)
						repeats = repeats + 1'b1;
					if (code != accepted) begin
						accepted = code;
						held = 1'b0;
						for (i = 0; i < QUEUE_DEPTH; i++)
							if (i < fill && code_store[i] == code)
								held = 1'b1;
						if (!held) begin
							if (fill < QUEUE_DEPTH) begin
								code_store[fill] = code;
								fill = fill + 1'b1;
							end else begin
								drop_oldest();
								code_store[QUEUE_DEPTH - 1] = code;
							end
							r.code_queued = 1'b1;
						end
					end
				end
			end
			synced = 1'b1;
			shift_word = '0;
			bit_cnt = '0;
		end else if (ticks > err_lim) begin
			synced = 1'b0;
			shift_word = '0;
			bit_cnt = '0;
		end else if (pin) begin
			if (!synced) begin
				shift_word = '0;
				bit_cnt = '0;
			end else begin
				if (bit_cnt < CODE_BITS)
					shift_word = {shift_word[CODE_BITS-2:0], ticks <= bit_thr};
				if (bit_cnt <= CODE_BITS)
					bit_cnt = bit_cnt + 1'b1;
			end
		end
		r.repeat_count = repeats;
		r.queue_count = fill;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] exp_val);
		$display("MISMATCH at result %0d, %s: got 0x%0h, expected 0x%0h",
			results_checked, field, got, exp_val);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_min = SYNC_RESET;
			synced = 1'b0;
			bit_thr = '0;
			err_lim = '0;
			shift_word = '0;
			bit_cnt = '0;
			prev_frame = '0;
			accepted = '0;
			repeats = '0;
			for (int i = 0; i < QUEUE_DEPTH; i++)
				code_store[i] = '0;
			fill = '0;
			decodes_due.delete();
			pending = 0;
			fails = 0;
			results_checked = 0;
			frames_seen = 0;
			codes_queued_seen = 0;
			codes_popped = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				sync_min = cfg_data;
			if (in_valid && !in_stall)
				decodes_due.push_back(predict_decode(opcode, interval_ticks, pin_level));
			if (out_valid && !out_stall) begin
				if (decodes_due.size() == 0) begin
					report_mismatch("result with no request waiting", 32'(frame_code), 0);
				end else begin
					want = decodes_due.pop_front();
					if (frame_done !== want.frame_done)
						report_mismatch("frame_done", 32'(frame_done), 32'(want.frame_done));
					if (frame_code !== want.frame_code)
						report_mismatch("frame_code", 32'(frame_code), 32'(want.frame_code));
					if (repeat_count !== want.repeat_count)
						report_mismatch("repeat_count", 32'(repeat_count),
							32'(want.repeat_count));
					if (code_queued !== want.code_queued)
						report_mismatch("code_queued", 32'(code_queued), 32'(want.code_queued));
					if (pop_valid !== want.pop_valid)
						report_mismatch("pop_valid", 32'(pop_valid), 32'(want.pop_valid));
					if (pop_code !== want.pop_code)
						report_mismatch("pop_code", 32'(pop_code), 32'(want.pop_code));
					if (queue_count !== want.queue_count)
						report_mismatch("queue_count", 32'(queue_count), 32'(want.queue_count));
					results_checked++;
					frames_seen += want.frame_done;
					codes_queued_seen += want.code_queued;
					codes_popped += want.pop_valid;
				end
			end
			pending = decodes_due.size();
		end
	end

endmodule

// ----- tb/sv/ook_pulse_width_code_receiver_core_tb.sv -----
`timescale 1ns / 1ps

module ook_pulse_width_code_receiver_core_tb;

	import okr_pkg::*;

	localparam int CODE_BITS = 24;
	localparam int QUEUE_DEPTH = 5;
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam int POOL_SIZE = 7;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 3000;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [TICK_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic opcode;
	logic [TICK_W-1:0] interval_ticks;
	logic pin_level;
	logic out_valid;
	logic out_stall;
	logic frame_done;
	logic [CODE_BITS-1:0] frame_code;
	logic [REPEAT_W-1:0] repeat_count;
	logic code_queued;
	logic pop_valid;
	logic [CODE_BITS-1:0] pop_code;
	logic [FILL_W-1:0] queue_count;

	int fails;
	int pending;
	int results_checked;
	int frames_seen;
	int codes_queued_seen;
	int codes_popped;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int items_sent = 0;
	int quiet_cycles = 0;
	logic hold_off_go = 1'b0;
	logic [TICK_W-1:0] sync_level = SYNC_RESET;
	logic [CODE_BITS-1:0] code_pool [0:POOL_SIZE-1];

	always #5 clk = ~clk;

	ook_pulse_width_code_receiver_core #(
		.CODE_BITS(CODE_BITS),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.interval_ticks(interval_ticks),
		.pin_level(pin_level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.frame_done(frame_done),
		.frame_code(frame_code),
		.repeat_count(repeat_count),
		.code_queued(code_queued),
		.pop_valid(pop_valid),
		.pop_code(pop_code),
		.queue_count(queue_count)
	);

	okr_code_tracker #(
		.CODE_BITS(CODE_BITS),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) tracker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.interval_ticks(interval_ticks),
		.pin_level(pin_level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.frame_done(frame_done),
		.frame_code(frame_code),
		.repeat_count(repeat_count),
		.code_queued(code_queued),
		.pop_valid(pop_valid),
		.pop_code(pop_code),
		.queue_count(queue_count),
		.fails(fails),
		.pending(pending),
		.results_checked(results_checked),
		.frames_seen(frames_seen),
		.codes_queued_seen(codes_queued_seen),
		.codes_popped(codes_popped)
	);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// The receiver side: random stalls, or one long hold-off when requested.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_go) begin
				hold_off_go = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	task automatic send_request(input logic op, input logic [TICK_W-1:0] ticks,
			input logic pin);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		interval_ticks <= ticks;
		pin_level <= pin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	// A sync gap followed by nbits rising edges, sometimes with falling edges between.
	task automatic send_frame(input logic [CODE_BITS-1:0] code, input int nbits);
		int lo, hi, thr, err, ticks;
		logic b;
		lo = int'(sync_level) + 1;
		hi = 5 * int'(sync_level);
		if (hi > 65535)
			hi = 65535;
		ticks = $urandom_range(hi, lo);
		thr = ticks / 16;
		err = 3 * thr;
		send_request(OP_EDGE, 16'(ticks), 1'($urandom));
		for (int i = 0; i < nbits; i++) begin
			if ($urandom_range(3) == 0)
				send_request(OP_EDGE, 16'($urandom_range(err)), 1'b0);
			b = (i < CODE_BITS) ? code[CODE_BITS-1-i] : 1'($urandom);
			if (b)
				ticks = ($urandom_range(3) == 0) ? thr : $urandom_range(thr);
			else
				ticks = ($urandom_range(3) == 0) ? err : $urandom_range(err, thr + 1);
			send_request(OP_EDGE, 16'(ticks), 1'b1);
		end
	endtask

	task automatic set_sync_threshold(input logic [TICK_W-1:0] value);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		sync_level = value;
	endtask

	task automatic random_step();
		int pick;
		logic frames_ok;
		logic [CODE_BITS-1:0] code;
		logic [TICK_W-1:0] t;
		pick = $urandom_range(99);
		frames_ok = (sync_level >= 2000) && (sync_level <= 20000);
		code = code_pool[$urandom_range(POOL_SIZE - 1)];
		if (frames_ok && pick < 60) begin
			repeat ($urandom_range(3, 1)) send_frame(code, CODE_BITS);
		end else if (frames_ok && pick < 72) begin
			send_frame(code, $urandom_range(CODE_BITS + 3));
			if ($urandom_range(1))
				send_request(OP_EDGE,
					16'($urandom_range(sync_level, sync_level - sync_level / 16 + 1)),
					1'($urandom));
		end else if (pick < 86) begin
			repeat ($urandom_range(3, 1)) send_request(OP_POP, 16'($urandom), 1'($urandom));
		end else begin
			repeat ($urandom_range(4, 1)) begin
				case ($urandom_range(3))
					0, 1: t = 16'($urandom);
					2: t = sync_level + 16'($urandom_range(1));
					default: t = 16'($urandom_range(3000));
				endcase
				send_request(1'($urandom), t, 1'($urandom));
			end
		end
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct,
			input logic [TICK_W-1:0] level, input int n_items, input logic pressure);
		int start;
		set_sync_threshold(level);
		@(posedge clk);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		if (pressure)
			hold_off_go = 1'b1;
		@(negedge clk);
		start = items_sent;
		while (items_sent - start < n_items)
			random_step();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		opcode = OP_EDGE;
		interval_ticks = '0;
		pin_level = 1'b0;
		code_pool[0] = '0;
		code_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			code_pool[i] = CODE_BITS'($urandom);
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_request(OP_POP, 16'hFFFF, 1'b1);
		send_request(OP_EDGE, 16'd5, 1'b1);
		send_request(OP_EDGE, 16'd0, 1'b0);
		send_request(OP_EDGE, 16'hFFFF, 1'b0);
		send_request(OP_EDGE, 16'd0, 1'b1);
		send_request(OP_EDGE, 16'd4095, 1'b1);
		send_request(OP_EDGE, 16'd4096, 1'b1);
		send_request(OP_EDGE, 16'd9000, 1'b0);
		send_request(OP_EDGE, 16'd9000, 1'b1);
		send_request(OP_EDGE, 16'd9001, 1'b1);
		send_request(OP_EDGE, 16'd1686, 1'b1);
		send_request(OP_EDGE, 16'd1687, 1'b1);
		send_request(OP_EDGE, 16'd10, 1'b1);
		send_request(OP_EDGE, 16'd9001, 1'b0);
		send_request(OP_EDGE, 16'd1687, 1'b0);
		send_request(OP_POP, 16'h0000, 1'b0);

		run_phase(0, 0, SYNC_RESET, 100, 1'b1);
		run_phase(78, 0, 16'(2000 + $urandom_range(10000)), 100, 1'b0);
		run_phase(0, 78, 16'd20000, 100, 1'b0);
		run_phase(16, 16, 16'd3000, 100, 1'b0);
		run_phase(16, 16, 16'd0, 20, 1'b0);
		run_phase(0, 0, 16'hFFFF, 20, 1'b0);

		// Two identical frames and a closing sync put a code into the queue.
		run_phase(0, 0, SYNC_RESET, 0, 1'b0);
		repeat (2) send_frame(code_pool[2], CODE_BITS);
		send_frame(code_pool[2], 0);
		repeat (QUEUE_DEPTH + 1) send_request(OP_POP, 16'($urandom), 1'($urandom));

		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		$display("Sent %0d requests under four stall patterns and six sync thresholds,",
			items_sent);
		$display("checked %0d results: %0d frames, %0d codes queued, %0d codes popped.",
			results_checked, frames_seen, codes_queued_seen, codes_popped);
		if (fails == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- ook_pulse_width_code_receiver_core.f -----
src/okr_pkg.sv
src/okr_fifo.sv
src/okr_front.sv
src/okr_back.sv
src/ook_pulse_width_code_receiver_core.sv
tb/sv/okr_code_tracker.sv
tb/sv/ook_pulse_width_code_receiver_core_tb.sv
